[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the point classifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PPC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is held.
`define PPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[rtl/ppc_pkg.sv]
// ----------------------------------------------------------------------------
// ppc_pkg
// Widths, types, register indexes and helpers of the point classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int PACK_W      = 16;
    localparam int CFG_W       = 3 * PACK_W;
    localparam int CFG_IDX_W   = 3;
    localparam int LOG_FRAC    = 14;
    localparam int ONE_LOG     = 1 << LOG_FRAC;

    localparam int VEC_W   = ((COORD_WIDTH > PACK_W) ? COORD_WIDTH : PACK_W) + 1;
    localparam int PROD_W  = PACK_W + VEC_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int LG_SHIFT = 6;
    localparam int PH_SHIFT = LOG_FRAC;
    localparam int LG_W    = SUM_W - LG_SHIFT;
    localparam int PH_W    = SUM_W - PH_SHIFT + 1;
    localparam int DIST_W  = LG_W;
    localparam int SAT_W   = (LG_W > PH_W) ? LG_W : PH_W;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [PACK_W-1:0]      t_part;
    typedef logic signed [VEC_W-1:0]       t_vec;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic signed [LG_W-1:0]        t_lg;
    typedef logic signed [PH_W-1:0]        t_ph;
    typedef logic [DIST_W-1:0]             t_dist;
    typedef logic [CFG_W-1:0]              t_word;

    typedef t_part  t_mat3 [3][3];
    typedef t_vec   t_vec3 [3];
    typedef t_sum   t_sum3 [3];
    typedef t_coord t_coord3 [3];
    typedef t_lg    t_lg3 [3];

    localparam t_sum LG_BIAS = SUM_W'(1) <<< (LG_SHIFT - 1);
    localparam t_sum PH_BIAS = SUM_W'(1) <<< (PH_SHIFT - 1);
    localparam t_lg  ONE_LG  = LG_W'(ONE_LOG);

    localparam logic signed [SAT_W-1:0] SAT_HI = (SAT_W'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE_A,
        CFG_EDGE_B,
        CFG_EDGE_C,
        CFG_ORIGIN_SHIFT,
        CFG_INV_ROW_ONE,
        CFG_INV_ROW_TWO,
        CFG_INV_ROW_THREE
    } t_cfg_idx;

    typedef enum logic [2:0] {
        FACE_L1_LO,
        FACE_L1_HI,
        FACE_L2_LO,
        FACE_L2_HI,
        FACE_L3_LO,
        FACE_L3_HI
    } t_face;

    function automatic t_part part(input t_word w, input int k);
        return t_part'(w[k*PACK_W +: PACK_W]);
    endfunction

    function automatic t_coord sat_coord(input logic signed [SAT_W-1:0] v);
        if (v > SAT_HI) begin
            return t_coord'(SAT_HI);
        end else if (v < SAT_LO) begin
            return t_coord'(SAT_LO);
        end
        return t_coord'(v);
    endfunction

endpackage

`default_nettype wire

[rtl/ppc_mac3.sv]
// ----------------------------------------------------------------------------
// ppc_mac3
// Two-stage three by three matrix-vector multiply with a rounding bias.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppc_mac3 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ppc_pkg::t_mat3 i_mat,
    input  ppc_pkg::t_vec3 i_vec,
    input  ppc_pkg::t_sum  i_bias,
    output logic          o_valid,
    output ppc_pkg::t_sum3 o_sum
);
    import ppc_pkg::*;

    logic                      r_v_prod;
    logic                      r_v_sum;
    logic signed [PROD_W-1:0]  n_prod [3][3];
    logic signed [PROD_W-1:0]  r_prod [3][3];
    t_sum3                     n_sum;
    t_sum3                     r_sum;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                n_prod[k][j] = PROD_W'(i_mat[k][j]) * PROD_W'(i_vec[j]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = SUM_W'(r_prod[k][0]) + SUM_W'(r_prod[k][1])
                     + SUM_W'(r_prod[k][2]) + i_bias;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_prod <= 1'b0;
            r_v_sum  <= 1'b0;
        end else begin
            r_v_prod <= i_valid;
            r_v_sum  <= r_v_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_sum  <= n_sum;
    end

    assign o_valid = r_v_sum;
    assign o_sum   = r_sum;

endmodule

`default_nettype wire

[rtl/parallelepiped_point_classifier.sv]
// ----------------------------------------------------------------------------
// parallelepiped_point_classifier
// Classifies a point against a parallelepiped and maps it between spaces.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and never raises busy. Each
// result is shown for one cycle under o_valid, seven cycles after the edge
// that accepts its item, and must be taken then. The latency of eight
// register stages comes from the input stage, the offset subtraction, two
// stages of each of the two matrix-vector units, the logical coordinate
// stage between them and the output stage.
// Configuration writes are always accepted and take effect at once.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module parallelepiped_point_classifier (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_mode,
    input  logic signed [ppc_pkg::COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [ppc_pkg::COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [ppc_pkg::COORD_WIDTH-1:0] i_coord_z,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [ppc_pkg::CFG_W-1:0]              i_cfg_data,
    output logic                                   o_valid,
    output logic signed [ppc_pkg::COORD_WIDTH-1:0] o_logical_one,
    output logic signed [ppc_pkg::COORD_WIDTH-1:0] o_logical_two,
    output logic signed [ppc_pkg::COORD_WIDTH-1:0] o_logical_three,
    output logic signed [ppc_pkg::COORD_WIDTH-1:0] o_point_x,
    output logic signed [ppc_pkg::COORD_WIDTH-1:0] o_point_y,
    output logic signed [ppc_pkg::COORD_WIDTH-1:0] o_point_z,
    output logic                                   o_is_inside,
    output logic [2:0]                             o_face_index
);
    import ppc_pkg::*;

    t_word   r_edge [3];
    t_word   r_inv [3];
    t_word   r_origin;
    t_mat3   inv_mat;
    t_mat3   edge_mat;
    t_part   off [3];

    logic    r_v1, r_v2, r_v5, r_v8;
    logic    r_mode1, r_mode2, r_mode3, r_mode4, r_mode5;
    t_coord3 r_c1, r_c2, r_c3, r_c4;
    t_vec3   n_d2, r_d2;
    t_lg3    n_lg5, r_lg5, r_lg6, r_lg7;
    t_vec3   sel;
    t_dist   n_dist6 [6];
    t_dist   r_dist6 [6];
    logic    n_inside6, r_inside6, r_inside7;
    t_face   n_face7, r_face7;
    t_dist   m01, m23, m45, m03;
    t_face   f01, f23, f45, f03;
    logic    w_v4, w_v7;
    t_sum3   w_sum1, w_sum2;
    t_ph     ph [3];
    t_coord3 n_lg_out, r_lg_out, n_ph_out, r_ph_out;
    logic    r_inside_out;
    t_face   r_face_out;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge[0] <= '0;
            r_edge[1] <= '0;
            r_edge[2] <= '0;
            r_origin  <= '0;
            r_inv[0]  <= '0;
            r_inv[1]  <= '0;
            r_inv[2]  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EDGE_A:        r_edge[0] <= i_cfg_data;
                CFG_EDGE_B:        r_edge[1] <= i_cfg_data;
                CFG_EDGE_C:        r_edge[2] <= i_cfg_data;
                CFG_ORIGIN_SHIFT:  r_origin  <= i_cfg_data;
                CFG_INV_ROW_ONE:   r_inv[0]  <= i_cfg_data;
                CFG_INV_ROW_TWO:   r_inv[1]  <= i_cfg_data;
                CFG_INV_ROW_THREE: r_inv[2]  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            off[k] = part(r_origin, k);
            for (int j = 0; j < 3; j++) begin
                inv_mat[k][j]  = part(r_inv[k], j);
                edge_mat[k][j] = part(r_edge[j], k);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_d2[k] = VEC_W'(r_c1[k]) - VEC_W'(off[k]);
        end
    end

    ppc_mac3 u_to_logical (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_mat   (inv_mat),
        .i_vec   (r_d2),
        .i_bias  (LG_BIAS),
        .o_valid (w_v4),
        .o_sum   (w_sum1)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lg5[k] = r_mode4 ? LG_W'(r_c4[k]) : t_lg'($signed(w_sum1[k][SUM_W-1:LG_SHIFT]));
        end
    end

    always_comb begin
        logic signed [LG_W:0] lo;
        logic signed [LG_W:0] hi;
        n_inside6 = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (r_lg5[k] < 0) begin
                sel[k] = '0;
            end else if (r_lg5[k] > ONE_LG) begin
                sel[k] = VEC_W'(ONE_LOG);
            end else begin
                sel[k] = VEC_W'(r_lg5[k]);
            end
            if (r_mode5) begin
                sel[k] = VEC_W'(r_lg5[k]);
            end
            if (r_lg5[k] < 0 || r_lg5[k] > ONE_LG) begin
                n_inside6 = 1'b0;
            end
            lo = (LG_W + 1)'(r_lg5[k]);
            hi = (LG_W + 1)'(ONE_LG) - (LG_W + 1)'(r_lg5[k]);
            n_dist6[2*k]   = DIST_W'((lo < 0) ? -lo : lo);
            n_dist6[2*k+1] = DIST_W'((hi < 0) ? -hi : hi);
        end
    end

    ppc_mac3 u_to_physical (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v5),
        .i_mat   (edge_mat),
        .i_vec   (sel),
        .i_bias  (PH_BIAS),
        .o_valid (w_v7),
        .o_sum   (w_sum2)
    );

    always_comb begin
        f01 = (r_dist6[1] < r_dist6[0]) ? FACE_L1_HI : FACE_L1_LO;
        m01 = (r_dist6[1] < r_dist6[0]) ? r_dist6[1] : r_dist6[0];
        f23 = (r_dist6[3] < r_dist6[2]) ? FACE_L2_HI : FACE_L2_LO;
        m23 = (r_dist6[3] < r_dist6[2]) ? r_dist6[3] : r_dist6[2];
        f45 = (r_dist6[5] < r_dist6[4]) ? FACE_L3_HI : FACE_L3_LO;
        m45 = (r_dist6[5] < r_dist6[4]) ? r_dist6[5] : r_dist6[4];
        f03 = (m23 < m01) ? f23 : f01;
        m03 = (m23 < m01) ? m23 : m01;
        n_face7 = (m45 < m03) ? f45 : f03;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ph[k] = PH_W'($signed(w_sum2[k][SUM_W-1:PH_SHIFT])) + PH_W'(off[k]);
            n_ph_out[k] = sat_coord(SAT_W'(ph[k]));
            n_lg_out[k] = sat_coord(SAT_W'(r_lg7[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v5 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v5 <= w_v4;
            r_v8 <= w_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode1      <= i_mode;
        r_c1         <= '{i_coord_x, i_coord_y, i_coord_z};
        r_mode2      <= r_mode1;
        r_c2         <= r_c1;
        r_d2         <= n_d2;
        r_mode3      <= r_mode2;
        r_c3         <= r_c2;
        r_mode4      <= r_mode3;
        r_c4         <= r_c3;
        r_mode5      <= r_mode4;
        r_lg5        <= n_lg5;
        r_lg6        <= r_lg5;
        r_dist6      <= n_dist6;
        r_inside6    <= n_inside6;
        r_lg7        <= r_lg6;
        r_face7      <= n_face7;
        r_inside7    <= r_inside6;
        r_lg_out     <= n_lg_out;
        r_ph_out     <= n_ph_out;
        r_inside_out <= r_inside7;
        r_face_out   <= r_face7;
    end

    assign o_valid         = r_v8;
    assign o_logical_one   = r_lg_out[0];
    assign o_logical_two   = r_lg_out[1];
    assign o_logical_three = r_lg_out[2];
    assign o_point_x       = r_ph_out[0];
    assign o_point_y       = r_ph_out[1];
    assign o_point_z       = r_ph_out[2];
    assign o_is_inside     = r_inside_out;
    assign o_face_index    = r_face_out;

    `PPC_ASSERT_IMP(a_result_has_item, i_clk, i_rst_n, o_valid, $past(start && !busy, 8))
    `PPC_ASSERT_IMP(a_face_in_range, i_clk, i_rst_n, o_valid, o_face_index <= FACE_L3_HI)
    `PPC_ASSERT_IMP(a_inside_bounds, i_clk, i_rst_n, o_valid && o_is_inside, o_logical_one >= 0 && o_logical_one <= ONE_LOG && o_logical_two >= 0 && o_logical_two <= ONE_LOG && o_logical_three >= 0 && o_logical_three <= ONE_LOG)
    `PPC_ASSERT_NEXT(a_mac_latency, i_clk, i_rst_n, r_v5, $past(r_v2, 4))

endmodule

`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the parallelepiped point classifier. A scoreboard
// predicts every accepted item from its own copy of the shape registers and
// compares each strobed result field by field. Directed items cover the
// field extremes, the faces, the ties and the unit bounds; random phases
// then load boxes, extreme and random shapes and mix well-formed points with
// noise, while the sender idles in random bursts in all but the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import ppc_pkg::*;

    localparam logic MODE_CLASSIFY = 1'b0;
    localparam logic MODE_MAP      = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam int NUM_SHAPE_REGS = int'(CFG_INV_ROW_THREE) + 1;
    localparam int PHASES = 10;
    localparam int POINTS_PER_PHASE = 85;
    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] logical;
        logic [2:0][COORD_WIDTH-1:0] point;
        logic                        in_box;
        t_face                       face;
    } t_point_result;

    class point_board;
        logic [CFG_W-1:0] shape_regs [NUM_SHAPE_REGS];
        t_point_result    expected_points [$];
        int               errors;

        function new();
            foreach (shape_regs[i]) shape_regs[i] = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            if (index <= CFG_INV_ROW_THREE) begin
                shape_regs[index] = data;
            end
        endfunction

        function longint coeff(int r, int k);
            logic signed [PACK_W-1:0] p;
            p = shape_regs[r][PACK_W*k +: PACK_W];
            return p;
        endfunction

        function longint round_to(longint v, int n);
            return (v + (longint'(1) <<< (n - 1))) >>> n;
        endfunction

        function logic [COORD_WIDTH-1:0] clip(longint v);
            longint hi;
            hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
            if (v > hi) begin
                v = hi;
            end else if (v < -hi - 1) begin
                v = -hi - 1;
            end
            return v[COORD_WIDTH-1:0];
        endfunction

        function void to_space(input longint lg [3], output longint ph [3]);
            longint s;
            for (int k = 0; k < 3; k++) begin
                s = coeff(int'(CFG_EDGE_A), k) * lg[0] + coeff(int'(CFG_EDGE_B), k) * lg[1]
                    + coeff(int'(CFG_EDGE_C), k) * lg[2];
                ph[k] = round_to(s, LOG_FRAC) + coeff(int'(CFG_ORIGIN_SHIFT), k);
            end
        endfunction

        function void note_point(logic mode, logic signed [COORD_WIDTH-1:0] x,
                                 logic signed [COORD_WIDTH-1:0] y,
                                 logic signed [COORD_WIDTH-1:0] z);
            longint        c [3];
            longint        lg [3];
            longint        cl [3];
            longint        ph [3];
            longint        d [3];
            longint        face_gap [6];
            longint        best;
            int            face;
            bit            in_unit;
            t_point_result want;
            c[0] = x;
            c[1] = y;
            c[2] = z;
            if (mode == MODE_CLASSIFY) begin
                for (int k = 0; k < 3; k++) d[k] = c[k] - coeff(int'(CFG_ORIGIN_SHIFT), k);
                for (int k = 0; k < 3; k++) begin
                    lg[k] = round_to(coeff(int'(CFG_INV_ROW_ONE) + k, 0) * d[0]
                                     + coeff(int'(CFG_INV_ROW_ONE) + k, 1) * d[1]
                                     + coeff(int'(CFG_INV_ROW_ONE) + k, 2) * d[2], LG_SHIFT);
                    cl[k] = lg[k] < 0 ? 0 : (lg[k] > ONE_LOG ? ONE_LOG : lg[k]);
                end
                to_space(cl, ph);
            end else begin
                lg = c;
                to_space(lg, ph);
            end
            in_unit = 1'b1;
            for (int k = 0; k < 3; k++) begin
                if (lg[k] < 0 || lg[k] > ONE_LOG) in_unit = 1'b0;
                face_gap[2*k]     = lg[k] < 0 ? -lg[k] : lg[k];
                face_gap[2*k + 1] = ONE_LOG - lg[k] < 0 ? lg[k] - ONE_LOG : ONE_LOG - lg[k];
            end
            face = 0;
            best = face_gap[0];
            for (int k = 1; k < 6; k++) begin
                if (face_gap[k] < best) begin
                    best = face_gap[k];
                    face = k;
                end
            end
            for (int k = 0; k < 3; k++) begin
                want.logical[k] = clip(lg[k]);
                want.point[k]   = clip(ph[k]);
            end
            want.in_box = in_unit;
            want.face   = t_face'(face);
            expected_points.push_back(want);
        endfunction

        function void check_result(t_point_result got);
            t_point_result want;
            string         lg_names [3] = '{"logical_one", "logical_two", "logical_three"};
            string         pt_names [3] = '{"point_x", "point_y", "point_z"};
            if (expected_points.size() == 0) begin
                $error("result strobed with no item outstanding");
                errors++;
                return;
            end
            want = expected_points.pop_front();
            for (int k = 0; k < 3; k++) begin
                if (got.logical[k] !== want.logical[k]) begin
                    $error("%s: expected %0d, got %0d", lg_names[k],
                           $signed(want.logical[k]), $signed(got.logical[k]));
                    errors++;
                end
                if (got.point[k] !== want.point[k]) begin
                    $error("%s: expected %0d, got %0d", pt_names[k],
                           $signed(want.point[k]), $signed(got.point[k]));
                    errors++;
                end
            end
            if (got.in_box !== want.in_box) begin
                $error("is_inside: expected %0b, got %0b", want.in_box, got.in_box);
                errors++;
            end
            if (got.face !== want.face) begin
                $error("face_index: expected %0d, got %0d", want.face, got.face);
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic                          i_mode = MODE_CLASSIFY;
    logic signed [COORD_WIDTH-1:0] i_coord_x = '0;
    logic signed [COORD_WIDTH-1:0] i_coord_y = '0;
    logic signed [COORD_WIDTH-1:0] i_coord_z = '0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_W-1:0]              i_cfg_data = '0;
    logic                          o_valid;
    logic signed [COORD_WIDTH-1:0] o_logical_one;
    logic signed [COORD_WIDTH-1:0] o_logical_two;
    logic signed [COORD_WIDTH-1:0] o_logical_three;
    logic signed [COORD_WIDTH-1:0] o_point_x;
    logic signed [COORD_WIDTH-1:0] o_point_y;
    logic signed [COORD_WIDTH-1:0] o_point_z;
    logic                          o_is_inside;
    logic [2:0]                    o_face_index;

    point_board       board = new();
    logic [CFG_W-1:0] shape [NUM_SHAPE_REGS];
    int               box_edge [3];
    int               box_origin [3];
    bit               idle_on = 1'b1;
    int               quiet = 0;

    parallelepiped_point_classifier DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_coord_z       (i_coord_z),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_logical_one   (o_logical_one),
        .o_logical_two   (o_logical_two),
        .o_logical_three (o_logical_three),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y),
        .o_point_z       (o_point_z),
        .o_is_inside     (o_is_inside),
        .o_face_index    (o_face_index)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_point_result got;
        if (i_rst_n) begin
            if (o_valid) begin
                got.logical = {o_logical_three, o_logical_two, o_logical_one};
                got.point   = {o_point_z, o_point_y, o_point_x};
                got.in_box  = o_is_inside;
                got.face    = t_face'(o_face_index);
                board.check_result(got);
            end
            if (start && !busy) board.note_point(i_mode, i_coord_x, i_coord_y, i_coord_z);
            if (i_cfg_valid && o_cfg_ready) board.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("parallelepiped_point_classifier regression: fail");
            $finish;
        end
    end

    task automatic send_point(logic mode, logic [COORD_WIDTH-1:0] x,
                              logic [COORD_WIDTH-1:0] y, logic [COORD_WIDTH-1:0] z);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_mode    <= mode;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [COORD_WIDTH-1:0] place(int k, int l);
        return COORD_WIDTH'(box_origin[k] + ((box_edge[k] * l) >>> LOG_FRAC));
    endfunction

    task automatic send_box(int l0, int l1, int l2);
        send_point(MODE_CLASSIFY, place(0, l0), place(1, l1), place(2, l2));
    endtask

    function automatic int pick_logical();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return ONE_LOG;
            2: return $urandom_range(0, 1) ? -1 : ONE_LOG + 1;
            default: return int'($urandom_range(0, 24576)) - 4096;
        endcase
    endfunction

    task automatic write_shape(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_shape();
        for (int r = 0; r < NUM_SHAPE_REGS; r++) write_shape(CFG_IDX_W'(r), shape[r]);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        start <= 1'b0;
        while (board.expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void build_box();
        int inv [3];
        for (int k = 0; k < 3; k++) begin
            inv[k] = ((1 << 20) + box_edge[k] / 2) / box_edge[k];
        end
        shape[CFG_EDGE_A]        = {32'h0, 16'(box_edge[0])};
        shape[CFG_EDGE_B]        = {16'h0, 16'(box_edge[1]), 16'h0};
        shape[CFG_EDGE_C]        = {16'(box_edge[2]), 32'h0};
        shape[CFG_ORIGIN_SHIFT]  = {16'(box_origin[2]), 16'(box_origin[1]), 16'(box_origin[0])};
        shape[CFG_INV_ROW_ONE]   = {32'h0, 16'(inv[0])};
        shape[CFG_INV_ROW_TWO]   = {16'h0, 16'(inv[1]), 16'h0};
        shape[CFG_INV_ROW_THREE] = {16'(inv[2]), 32'h0};
    endfunction

    task automatic send_random_point();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
            send_box(pick_logical(), pick_logical(), pick_logical());
        end else if (pick <= 7) begin
            send_point(MODE_MAP, 16'(pick_logical()), 16'(pick_logical()), 16'(pick_logical()));
        end else begin
            send_point($urandom_range(0, 1) ? MODE_MAP : MODE_CLASSIFY,
                       16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Cleared registers map every point to the lower corner.
        send_point(MODE_CLASSIFY, 16'h0000, 16'h0000, 16'h0000);
        send_point(MODE_MAP, 16'(ONE_LOG), 16'(ONE_LOG), 16'(ONE_LOG));
        settle();

        // Unit cube away from the origin; the spare index must change nothing.
        box_edge   = '{256, 256, 256};
        box_origin = '{256, -256, 512};
        build_box();
        write_shape(CFG_IDX_SPARE, CFG_W'({$urandom, $urandom}));
        load_shape();
        send_box(0, 0, 0);
        send_box(8192, 8192, 8192);
        send_box(ONE_LOG, ONE_LOG, ONE_LOG);
        send_box(8192, 8192, 14746);
        send_box(8192, 1638, 8192);
        send_box(8192, 15565, 8192);
        send_box(819, 8192, 8192);
        send_box(15892, 8192, 8192);
        send_box(8192, 8192, 328);
        send_box(-16384, -16384, -16384);
        send_box(24576, 24576, 24576);
        send_point(MODE_CLASSIFY, 16'h7fff, 16'h7fff, 16'h7fff);
        send_point(MODE_CLASSIFY, 16'h8000, 16'h8000, 16'h8000);
        send_point(MODE_CLASSIFY, 16'h7fff, 16'h8000, 16'h0000);
        send_point(MODE_MAP, 16'h7fff, 16'h8000, 16'h0000);
        send_point(MODE_MAP, 16'(ONE_LOG), 16'(ONE_LOG + 1), 16'hffff);
        send_point(MODE_MAP, 16'h0000, 16'h0000, 16'h0000);
        send_point(MODE_MAP, 16'h8000, 16'h7fff, 16'(ONE_LOG));

        for (int p = 0; p < PHASES; p++) begin
            settle();
            idle_on = (p != PHASES - 1);
            case (p)
                1: foreach (shape[r]) shape[r] = {3{16'h7fff}};
                2: foreach (shape[r]) shape[r] = {3{16'h8000}};
                3: foreach (shape[r]) shape[r] = '1;
                4: foreach (shape[r]) shape[r] = CFG_W'({$urandom, $urandom});
                default: begin
                    for (int k = 0; k < 3; k++) begin
                        box_edge[k]   = $urandom_range(64, 2048);
                        box_origin[k] = int'($urandom_range(0, 2048)) - 1024;
                    end
                    build_box();
                end
            endcase
            load_shape();
            repeat (POINTS_PER_PHASE) send_random_point();
        end

        start <= 1'b0;
        while (board.expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.expected_points.size() == 0) begin
            $display("parallelepiped_point_classifier regression: pass");
        end else begin
            $display("parallelepiped_point_classifier regression: fail");
        end
        $finish;
    end

endmodule
